// ===== src/lebuf_pkg.sv =====
// lebuf_pkg: shared types and constants for the line edit buffer.
// Used by lebuf_ctrl, lebuf_dp and line_edit_buffer_core.
package lebuf_pkg;

    localparam int MAX_CHARS = 64;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int POS_W     = 7;
    localparam int OP_W      = 3;

    localparam logic [POS_W-1:0] CAP_RESET = POS_W'(64);
    localparam logic [POS_W-1:0] CAP_LIMIT = POS_W'(MAX_CHARS);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_OVERWRITE = 3'd1,
        OP_BACKSPACE = 3'd2,
        OP_DELETE    = 3'd3,
        OP_LEFT      = 3'd4,
        OP_RIGHT     = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic out_take;
    } lebuf_cmd_t;

endpackage

// ===== src/lebuf_ctrl.sv =====
// lebuf_ctrl: handshake controller, tracks whether the result word is held.
// Depends on lebuf_pkg.
module lebuf_ctrl
    import lebuf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output lebuf_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (in_valid)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!out_stall && !in_valid)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b0;
        out_valid    = 1'b0;
        cmd.out_take = 1'b0;
        case (state_reg)
            ST_EMPTY:
            begin
                in_stall = 1'b0;
            end
            ST_FULL:
            begin
                out_valid    = 1'b1;
                in_stall     = out_stall;
                cmd.out_take = !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        cmd.exec = in_valid && !in_stall;
    end

endmodule

// ===== src/lebuf_dp.sv =====
// lebuf_dp: character cell row, cursor, length, capacity and result word.
// Depends on lebuf_pkg.
module lebuf_dp
    import lebuf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lebuf_cmd_t        cmd,
    input  logic              cfg_wr_en,
    input  logic [POS_W-1:0]  cfg_wr_data,
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [IDX_W-1:0]  read_index,
    output logic [POS_W-1:0]  cursor_out,
    output logic [POS_W-1:0]  length_out,
    output logic [CHAR_W-1:0] read_char,
    output logic              changed
);

    logic [CHAR_W-1:0] text_reg  [MAX_CHARS];
    logic [CHAR_W-1:0] text_next [MAX_CHARS];
    logic [POS_W-1:0]  cursor_reg;
    logic [POS_W-1:0]  cursor_next;
    logic [POS_W-1:0]  len_reg;
    logic [POS_W-1:0]  len_next;
    logic [POS_W-1:0]  cap_reg;
    logic [CHAR_W-1:0] rd_reg;
    logic [CHAR_W-1:0] rd_next;
    logic              chg_reg;
    logic              chg_next;
    logic [POS_W-1:0]  cap_eff;
    logic [POS_W-1:0]  rm_pos;
    logic              do_ins;
    logic              do_ovr;
    logic              do_rm;
    logic              do_clr;

    assign cap_eff = (cap_reg < CAP_LIMIT) ? cap_reg : CAP_LIMIT;

    always_comb
    begin
        cursor_next = cursor_reg;
        len_next    = len_reg;
        rd_next     = '0;
        chg_next    = 1'b0;
        rm_pos      = cursor_reg;
        do_ins      = 1'b0;
        do_ovr      = 1'b0;
        do_rm       = 1'b0;
        do_clr      = 1'b0;
        case (op_t'(op))
            OP_INSERT:
            begin
                if (len_reg < cap_eff)
                begin
                    do_ins      = 1'b1;
                    len_next    = len_reg + POS_W'(1);
                    cursor_next = cursor_reg + POS_W'(1);
                    chg_next    = 1'b1;
                end
            end
            OP_OVERWRITE:
            begin
                if (cursor_reg < cap_eff)
                begin
                    do_ovr      = 1'b1;
                    cursor_next = cursor_reg + POS_W'(1);
                    chg_next    = 1'b1;
                    if (cursor_reg == len_reg)
                    begin
                        len_next = len_reg + POS_W'(1);
                    end
                end
            end
            OP_BACKSPACE:
            begin
                rm_pos = cursor_reg - POS_W'(1);
                if (cursor_reg != '0)
                begin
                    do_rm       = 1'b1;
                    len_next    = len_reg - POS_W'(1);
                    cursor_next = cursor_reg - POS_W'(1);
                    chg_next    = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cursor_reg < len_reg)
                begin
                    do_rm    = 1'b1;
                    len_next = len_reg - POS_W'(1);
                    chg_next = 1'b1;
                end
            end
            OP_LEFT:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - POS_W'(1);
                    chg_next    = 1'b1;
                end
            end
            OP_RIGHT:
            begin
                if (cursor_reg < len_reg)
                begin
                    cursor_next = cursor_reg + POS_W'(1);
                    chg_next    = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                do_clr      = 1'b1;
                chg_next    = (len_reg != '0) || (cursor_reg != '0);
                len_next    = '0;
                cursor_next = '0;
            end
            OP_READ:
            begin
                if ({1'b0, read_index} < len_reg)
                begin
                    rd_next = text_reg[read_index];
                end
            end
            default:
            begin
                rd_next = '0;
            end
        endcase
    end

    // each cell keeps its value or picks its left neighbor, right neighbor, the new char or zero
    always_comb
    begin
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            text_next[i] = text_reg[i];
            if (do_clr)
            begin
                text_next[i] = '0;
            end
            else if (do_ins)
            begin
                if (POS_W'(i) == cursor_reg)
                begin
                    text_next[i] = char_in;
                end
                else if (POS_W'(i) > cursor_reg)
                begin
                    text_next[i] = text_reg[(i + MAX_CHARS - 1) % MAX_CHARS];
                end
            end
            else if (do_ovr)
            begin
                if (POS_W'(i) == cursor_reg)
                begin
                    text_next[i] = char_in;
                end
            end
            else if (do_rm)
            begin
                if (POS_W'(i) >= rm_pos)
                begin
                    if (i == MAX_CHARS - 1)
                    begin
                        text_next[i] = '0;
                    end
                    else
                    begin
                        text_next[i] = text_reg[(i + 1) % MAX_CHARS];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHARS; i++)
            begin
                text_reg[i] <= '0;
            end
            cursor_reg <= '0;
            len_reg    <= '0;
            cap_reg    <= CAP_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                text_reg   <= text_next;
                cursor_reg <= cursor_next;
                len_reg    <= len_next;
            end
        end
    end

    // result word; cursor and length come straight from state
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rd_reg  <= rd_next;
            chg_reg <= chg_next;
        end
        else if (cmd.out_take)
        begin
            rd_reg  <= rd_reg;
            chg_reg <= chg_reg;
        end
    end

    assign cursor_out = cursor_reg;
    assign length_out = len_reg;
    assign read_char  = rd_reg;
    assign changed    = chg_reg;

endmodule

// ===== src/line_edit_buffer_core.sv =====
// line_edit_buffer_core: top level of the line edit buffer.
// Depends on lebuf_pkg, lebuf_ctrl, lebuf_dp.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------------
//  in      | in_valid / in_stall         | op, char_in, read_index
//  out     | out_valid / out_stall       | cursor_out, length_out, read_char, changed
//  cfg     | cfg_wr_en                   | cfg_wr_data (capacity)
//
// One word per cycle while in_stall is low; its result shows in the cycle after acceptance.
// Every cell of the line updates in the same cycle.
// Reset clears the line, cursor and length; capacity resets to 64.
// in_stall rises only while a result word is held and out_stall is high.
module line_edit_buffer_core
    import lebuf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [IDX_W-1:0]  read_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  cursor_out,
    output logic [POS_W-1:0]  length_out,
    output logic [CHAR_W-1:0] read_char,
    output logic              changed,
    input  logic              cfg_wr_en,
    input  logic [POS_W-1:0]  cfg_wr_data
);

    lebuf_cmd_t cmd;

    lebuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lebuf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .char_in     (char_in),
        .read_index  (read_index),
        .cursor_out  (cursor_out),
        .length_out  (length_out),
        .read_char   (read_char),
        .changed     (changed)
    );

endmodule
